### design/xcfb_pkg.sv
package xcfb_pkg;

  localparam int BYTE_W = 8;
  localparam int ADDR_W = 16;
  localparam int CNT_W  = 8;
  localparam int SUM_W  = CNT_W + 1;

  localparam int HDR_LEN = 5;

  typedef logic [2:0] hdr_idx_t;

  localparam hdr_idx_t HDR_TYPE  = 3'd0;
  localparam hdr_idx_t HDR_CMD   = 3'd1;
  localparam hdr_idx_t HDR_ADDRH = 3'd2;
  localparam hdr_idx_t HDR_ADDRL = 3'd3;
  localparam hdr_idx_t HDR_COUNT = 3'd4;

  typedef logic [2:0] src_t;

  localparam src_t SRC_HDR  = 3'd0;
  localparam src_t SRC_DATA = 3'd1;
  localparam src_t SRC_CHK  = 3'd2;
  localparam src_t SRC_REP  = 3'd3;
  localparam src_t SRC_ERR  = 3'd4;

  typedef struct packed {
    logic load_item;
    logic emit;
    src_t src;
    logic last;
    logic step_hdr;
    logic step_pos;
    logic start_rep;
  } cmd_t;

  typedef struct packed {
    logic first;
    logic item_bad;
    logic cnt_zero;
    logic pos_last;
    logic hdr_last;
    logic rep_last;
    logic out_free;
  } sts_t;

endpackage

### design/xcfb_cfg_if.sv
interface xcfb_cfg_if;
  import xcfb_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] frame_type_byte;

  modport source (output valid, output frame_type_byte, input ready);
  modport sink (input valid, input frame_type_byte, output ready);
endinterface

### design/xcfb_in_if.sv
interface xcfb_in_if;
  import xcfb_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] command;
  logic [ADDR_W-1:0] end_address;
  logic [CNT_W-1:0]  data_count;
  logic [BYTE_W-1:0] data_byte;

  modport source (
    output valid, output command, output end_address, output data_count,
    output data_byte, input ready
  );
  modport sink (
    input valid, input command, input end_address, input data_count,
    input data_byte, output ready
  );
endinterface

### design/xcfb_out_if.sv
interface xcfb_out_if;
  import xcfb_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              copy_number;
  logic              last_of_run;
  logic              bad_length;

  modport source (
    output valid, output out_byte, output copy_number, output last_of_run,
    output bad_length, input ready
  );
  modport sink (
    input valid, input out_byte, input copy_number, input last_of_run,
    input bad_length, output ready
  );
endinterface

### design/xor_checked_frame_builder.sv
// an item is taken into the controller state, its beats into the output
// register; a first item gives five header bytes, a middle payload item one
// byte; a final item adds check byte and replay, a byte per cycle unless stalled
// throughput: one item at a time, one output beat per cycle at most
// rst (synchronous) clears the controller, message position, check and type byte
module xor_checked_frame_builder #(
  parameter int MAX_DATA = 32
) (
  input logic        clk,
  input logic        rst,
  xcfb_cfg_if.sink   cfg,
  xcfb_in_if.sink    item,
  xcfb_out_if.source result
);
  import xcfb_pkg::*;

  cmd_t cmd;
  sts_t sts;

  xcfb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (item.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  xcfb_datapath #(
    .MAX_DATA (MAX_DATA)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .item   (item),
    .result (result),
    .cmd    (cmd),
    .sts    (sts)
  );

endmodule

### design/xcfb_datapath.sv
module xcfb_datapath #(
  parameter int MAX_DATA = 32
) (
  input  logic            clk,
  input  logic            rst,
  xcfb_cfg_if.sink        cfg,
  xcfb_in_if.sink         item,
  xcfb_out_if.source      result,
  input  xcfb_pkg::cmd_t  cmd,
  output xcfb_pkg::sts_t  sts
);
  import xcfb_pkg::*;

  localparam int DEPTH = MAX_DATA + HDR_LEN + 1;
  localparam int AW    = $clog2(DEPTH);

  logic [BYTE_W-1:0] frame_type;
  logic [BYTE_W-1:0] cmd_byte;
  logic [ADDR_W-1:0] address;
  logic [BYTE_W-1:0] payload;
  logic [CNT_W-1:0]  count;
  logic              bad;
  logic [CNT_W-1:0]  pos;
  hdr_idx_t          hdr_idx;
  logic [AW-1:0]     rep_idx;
  logic [BYTE_W-1:0] running_xor;
  logic [BYTE_W-1:0] rdata;
  logic [BYTE_W-1:0] frame_store [DEPTH];

  logic              first;
  logic              in_bad;
  logic [BYTE_W-1:0] hdr_byte;
  logic [BYTE_W-1:0] emit_byte;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;
  logic              store_wr;

  assign cfg.ready = 1'b1;

  assign first  = (pos == '0);
  assign in_bad = {1'b0, item.data_count} > SUM_W'(MAX_DATA);

  assign sts.first    = first;
  assign sts.item_bad = first ? in_bad : bad;
  assign sts.cnt_zero = (count == '0);
  assign sts.pos_last = ({1'b0, pos} + SUM_W'(1)) >= {1'b0, count};
  assign sts.hdr_last = (hdr_idx == HDR_COUNT);
  assign sts.rep_last = (SUM_W'(rep_idx) == ({1'b0, count} + SUM_W'(HDR_LEN)));
  assign sts.out_free = !result.valid || result.ready;

  always_comb begin
    unique case (hdr_idx)
      HDR_TYPE:  hdr_byte = frame_type;
      HDR_CMD:   hdr_byte = cmd_byte;
      HDR_ADDRH: hdr_byte = address[ADDR_W-1:BYTE_W];
      HDR_ADDRL: hdr_byte = address[BYTE_W-1:0];
      default:   hdr_byte = count;
    endcase
  end

  always_comb begin
    store_wr  = 1'b0;
    emit_byte = '0;
    waddr     = '0;
    unique case (cmd.src)
      SRC_HDR: begin
        emit_byte = hdr_byte;
        waddr     = AW'(hdr_idx);
        store_wr  = cmd.emit;
      end
      SRC_DATA: begin
        emit_byte = payload;
        waddr     = AW'(SUM_W'(pos) + SUM_W'(HDR_LEN));
        store_wr  = cmd.emit;
      end
      SRC_CHK: begin
        emit_byte = running_xor;
        waddr     = AW'({1'b0, count} + SUM_W'(HDR_LEN));
        store_wr  = cmd.emit;
      end
      SRC_REP: emit_byte = rdata;
      default: emit_byte = '0;
    endcase
  end

  always_comb begin
    if (cmd.start_rep) begin
      raddr = '0;
    end else if (cmd.emit && cmd.src == SRC_REP) begin
      raddr = rep_idx + AW'(1);
    end else begin
      raddr = rep_idx;
    end
  end

  // frame store
  always_ff @(posedge clk) begin
    if (store_wr) begin
      frame_store[waddr] <= emit_byte;
    end
    rdata <= frame_store[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      cmd_byte <= item.command;
      address  <= item.end_address;
      payload  <= item.data_byte;
    end
    if (cmd.start_rep) begin
      rep_idx <= '0;
    end else if (cmd.emit && cmd.src == SRC_REP) begin
      rep_idx <= rep_idx + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_type  <= '0;
      count       <= '0;
      bad         <= 1'b0;
      pos         <= '0;
      hdr_idx     <= HDR_TYPE;
      running_xor <= '0;
    end else begin
      if (cfg.valid) begin
        frame_type <= cfg.frame_type_byte;
      end
      if (cmd.load_item) begin
        hdr_idx <= HDR_TYPE;
        if (first) begin
          count       <= item.data_count;
          bad         <= in_bad;
          running_xor <= '0;
        end
      end
      if (cmd.step_hdr) begin
        hdr_idx <= hdr_idx + 3'd1;
      end
      if (cmd.step_pos) begin
        pos <= sts.pos_last ? '0 : pos + CNT_W'(1);
      end
      if (store_wr) begin
        running_xor <= running_xor ^ emit_byte;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (cmd.emit) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.out_byte    <= emit_byte;
      result.copy_number <= (cmd.src == SRC_REP);
      result.last_of_run <= cmd.last;
      result.bad_length  <= (cmd.src == SRC_ERR);
    end
  end

endmodule

### design/xcfb_ctrl.sv
module xcfb_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  xcfb_pkg::sts_t  sts,
  output xcfb_pkg::cmd_t  cmd
);
  import xcfb_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HDR  = 3'd1;
  localparam logic [2:0] S_DATA = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_REP  = 3'd4;
  localparam logic [2:0] S_ERR  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.src    = SRC_HDR;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          if (sts.item_bad) begin
            state_next = S_ERR;
          end else if (sts.first) begin
            state_next = S_HDR;
          end else begin
            state_next = S_DATA;
          end
        end
      end
      S_HDR: begin
        cmd.src = SRC_HDR;
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.step_hdr = 1'b1;
          if (sts.hdr_last) begin
            state_next = sts.cnt_zero ? S_CHK : S_DATA;
          end
        end
      end
      S_DATA: begin
        cmd.src  = SRC_DATA;
        cmd.last = !sts.pos_last;
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.step_pos = 1'b1;
          state_next   = sts.pos_last ? S_CHK : S_IDLE;
        end
      end
      S_CHK: begin
        cmd.src = SRC_CHK;
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.start_rep = 1'b1;
          state_next    = S_REP;
        end
      end
      S_REP: begin
        cmd.src  = SRC_REP;
        cmd.last = sts.rep_last;
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.rep_last) begin
            state_next = S_IDLE;
          end
        end
      end
      S_ERR: begin
        cmd.src  = SRC_ERR;
        cmd.last = 1'b1;
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.step_pos = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free)
    else $error("beat issued into a full output register");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state != S_IDLE)
    else $error("item accepted without work");

  a_rep_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_REP && cmd.emit && sts.rep_last) |=> state == S_IDLE)
    else $error("replay did not finish");

  a_zero_hdr: assert property (@(posedge clk) disable iff (rst)
    (state == S_HDR && cmd.emit && sts.hdr_last && sts.cnt_zero) |=> state == S_CHK)
    else $error("empty frame missed check byte");

endmodule

### tb/frame_checker.sv
module frame_checker #(
  parameter int MAX_DATA = 32
) (
  input  logic clk,
  input  logic rst,
  xcfb_cfg_if  cfg,
  xcfb_in_if   item,
  xcfb_out_if  result,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import xcfb_pkg::*;

  localparam int FRAME_LEN = MAX_DATA + HDR_LEN + 1;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              copy_number;
    logic              last_of_run;
    logic              bad_length;
  } wire_beat_t;

  wire_beat_t        beats_due[$];
  logic [BYTE_W-1:0] type_byte;
  logic [BYTE_W-1:0] frame_copy [FRAME_LEN];
  logic [BYTE_W-1:0] check_acc;
  int unsigned       msg_pos;
  int unsigned       msg_len;
  logic              msg_overlong;

  function automatic wire_beat_t wire_beat(input logic [BYTE_W-1:0] b, input logic copy,
                                           input logic last, input logic bad);
    wire_beat_t w;
    w.out_byte    = b;
    w.copy_number = copy;
    w.last_of_run = last;
    w.bad_length  = bad;
    return w;
  endfunction

  // first-copy byte: kept for the replay and folded into the check
  function automatic void send_byte(input int unsigned idx, input logic [BYTE_W-1:0] b);
    if (idx < FRAME_LEN) begin
      frame_copy[idx] = b;
    end
    check_acc ^= b;
    beats_due.push_back(wire_beat(b, 1'b0, 1'b0, 1'b0));
  endfunction

  function automatic void predict_frame_bytes(input logic [BYTE_W-1:0] cmd,
                                              input logic [ADDR_W-1:0] addr,
                                              input logic [CNT_W-1:0] cnt,
                                              input logic [BYTE_W-1:0] data);
    int   first_new;
    logic done;
    first_new = beats_due.size();
    done = 1'b0;
    if (msg_pos == 0) begin
      msg_len = cnt;
      msg_overlong = cnt > MAX_DATA;
      if (!msg_overlong) begin
        check_acc = '0;
        send_byte(HDR_TYPE, type_byte);
        send_byte(HDR_CMD, cmd);
        send_byte(HDR_ADDRH, addr[15:8]);
        send_byte(HDR_ADDRL, addr[7:0]);
        send_byte(HDR_COUNT, cnt);
        done = (cnt == 0);
      end
    end
    if (msg_overlong) begin
      beats_due.push_back(wire_beat('0, 1'b0, 1'b1, 1'b1));
      msg_pos++;
      if (msg_pos >= msg_len) begin
        msg_pos = 0;
      end
      return;
    end
    if (!done) begin
      send_byte(HDR_LEN + msg_pos, data);
      msg_pos++;
      done = (msg_pos >= msg_len);
    end
    if (done) begin
      send_byte(HDR_LEN + msg_len, check_acc);
      for (int i = 0; i < HDR_LEN + msg_len + 1; i++) begin
        beats_due.push_back(wire_beat(frame_copy[i], 1'b1, 1'b0, 1'b0));
      end
      msg_pos = 0;
      check_acc = '0;
    end
    if (beats_due.size() > first_new) begin
      beats_due[$].last_of_run = 1'b1;
    end
  endfunction

  task automatic report(input string msg);
    if (fail_count < 30) begin
      $display("%0t: %s", $time, msg);
    end
    fail_count++;
  endtask

  task automatic compare_beat();
    wire_beat_t want;
    if (beats_due.size() == 0) begin
      report($sformatf("unexpected beat, byte %02h", result.out_byte));
      return;
    end
    want = beats_due.pop_front();
    if (result.out_byte !== want.out_byte) begin
      report($sformatf("out_byte %02h, want %02h", result.out_byte, want.out_byte));
    end
    if (result.copy_number !== want.copy_number) begin
      report($sformatf("copy_number %b, want %b", result.copy_number, want.copy_number));
    end
    if (result.last_of_run !== want.last_of_run) begin
      report($sformatf("last_of_run %b, want %b", result.last_of_run, want.last_of_run));
    end
    if (result.bad_length !== want.bad_length) begin
      report($sformatf("bad_length %b, want %b", result.bad_length, want.bad_length));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      type_byte = '0;
      check_acc = '0;
      msg_pos = 0;
      msg_len = 0;
      msg_overlong = 1'b0;
      fail_count = 0;
      beats_due.delete();
    end else begin
      if (result.valid && result.ready) begin
        compare_beat();
      end
      if (cfg.valid && cfg.ready) begin
        type_byte = cfg.frame_type_byte;
      end
      if (item.valid && item.ready) begin
        predict_frame_bytes(item.command, item.end_address, item.data_count, item.data_byte);
      end
    end
    pending <= beats_due.size();
  end

endmodule

### tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import xcfb_pkg::*;

  localparam int MAX_DATA    = 32;
  localparam int ITEM_TARGET = 370;
  localparam int STALL_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst;
  int   fail_count;
  int   pending;
  int   items_sent = 0;
  int   idle_cycles = 0;
  int   hold_cycles = 0;
  logic quiet = 1'b0;

  xcfb_cfg_if cfg_ch ();
  xcfb_in_if  item_ch ();
  xcfb_out_if result_ch ();

  xor_checked_frame_builder #(
    .MAX_DATA(MAX_DATA)
  ) uut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .item   (item_ch),
    .result (result_ch)
  );

  frame_checker #(
    .MAX_DATA(MAX_DATA)
  ) chk (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_ch),
    .item       (item_ch),
    .result     (result_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  task automatic send_item(input logic [BYTE_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                           input logic [CNT_W-1:0] cnt, input logic [BYTE_W-1:0] data);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid       <= 1'b1;
    item_ch.command     <= cmd;
    item_ch.end_address <= addr;
    item_ch.data_count  <= cnt;
    item_ch.data_byte   <= data;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // header fields count only on the first beat, so later beats carry noise there
  task automatic send_message(input logic [BYTE_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                              input logic [CNT_W-1:0] cnt, input int fixed_data);
    int n;
    logic [BYTE_W-1:0] data;
    n = (cnt == 0) ? 1 : cnt;
    for (int i = 0; i < n; i++) begin
      data = (fixed_data < 0) ? 8'($urandom) : 8'(fixed_data);
      if (i == 0) begin
        send_item(cmd, addr, cnt, data);
      end else begin
        send_item(8'($urandom), 16'($urandom), 8'($urandom), data);
      end
    end
  endtask

  task automatic drain();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_type(input logic [BYTE_W-1:0] value);
    cfg_ch.valid           <= 1'b1;
    cfg_ch.frame_type_byte <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin : sink_side
    int gap;
    result_ch.ready <= 1'b0;
    forever begin
      if (hold_cycles > 0) begin
        result_ch.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else if (quiet) begin
        result_ch.ready <= 1'b1;
        @(posedge clk);
      end else begin
        result_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        gap = pick_gap();
        if (gap > 0) begin
          result_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [CNT_W-1:0] cnt;
    int r;
    rst                    <= 1'b1;
    item_ch.valid          <= 1'b0;
    item_ch.command        <= '0;
    item_ch.end_address    <= '0;
    item_ch.data_count     <= '0;
    item_ch.data_byte      <= '0;
    cfg_ch.valid           <= 1'b0;
    cfg_ch.frame_type_byte <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // header-only and short frames at the field extremes
    send_message(8'h00, 16'h0000, 8'd0, -1);
    send_message(8'hff, 16'hffff, 8'd0, -1);
    send_message(8'h5a, 16'h00ff, 8'd1, 8'hff);
    send_message(8'ha5, 16'hff00, 8'd2, 8'h00);

    // type byte changed mid-message only affects the next frame
    send_item(8'h3c, 16'h1234, 8'd3, 8'($urandom));
    drain();
    write_type(8'h81);
    send_item(8'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
    send_item(8'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));

    // just over the limit
    send_message(8'h11, 16'h8001, 8'(MAX_DATA + 1), -1);

    for (int ph = 0; items_sent < ITEM_TARGET; ph++) begin
      drain();
      write_type(ph == 0 ? 8'hff : ph == 1 ? 8'h00 : 8'($urandom));
      quiet = (ph == 1);
      if (ph == 0) begin
        hold_cycles = 300;
      end
      for (int m = 0; m < 6 && items_sent < ITEM_TARGET; m++) begin
        r = $urandom_range(0, 99);
        if (ph == 0 && m == 0) begin
          cnt = 8'(MAX_DATA);
        end else if (ph == 1 && m == 0) begin
          cnt = 8'($urandom_range(192, 255));
        end else if (r < 6) begin
          cnt = 8'($urandom_range(MAX_DATA + 1, MAX_DATA + 8));
        end else if (r < 20) begin
          cnt = 8'($urandom_range(MAX_DATA - 4, MAX_DATA));
        end else begin
          cnt = 8'($urandom_range(0, 6));
        end
        send_message(8'($urandom), 16'($urandom), cnt, -1);
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
